// ===== design/quad_dac_i2c_register_slave_top_macros.svh =====
// Assertion macros for the quad DAC register slave.
`ifndef QUAD_DAC_I2C_REGISTER_SLAVE_TOP_MACROS_SVH
`define QUAD_DAC_I2C_REGISTER_SLAVE_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, off while in reset
`define QDRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while in reset
`define QDRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/qdrs_pkg.sv =====
// Shared types and constants of the quad DAC register slave.
package qdrs_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W     = 2;
  localparam int WORD_W   = 16;
  localparam int CODE_W   = 15;  // word bits kept in the DAC RAM (vref lives in flops)

  // Request codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  // Configuration register indexes
  localparam logic [0:0] REG_ADDRESS_BITS = 1'd0;
  localparam logic [0:0] REG_BUSY_TICKS   = 1'd1;

  // Command byte opcodes (upper bits of the first byte)
  localparam logic [4:0] OP_MULTI  = 5'b01000;
  localparam logic [4:0] OP_SEQ    = 5'b01010;
  localparam logic [4:0] OP_SINGLE = 5'b01011;
  localparam logic [2:0] OP_VREF   = 3'b100;

  // Readback byte offsets within one channel
  localparam logic [2:0] OFF_DAC_HDR = 3'd0;
  localparam logic [2:0] OFF_DAC_HI  = 3'd1;
  localparam logic [2:0] OFF_EEP_HDR = 3'd3;
  localparam logic [2:0] OFF_EEP_HI  = 3'd4;
  localparam logic [2:0] OFF_LAST    = 3'd5;

  localparam logic [3:0] CNT_MAX   = 4'd15;
  localparam logic [3:0] CNT_DATA0 = 4'd3;

  typedef enum logic [2:0] {
    FK_IDLE    = 3'd0,
    FK_MULTI   = 3'd1,
    FK_SINGLE  = 3'd2,
    FK_SEQ     = 3'd3,
    FK_DONE    = 3'd4,
    FK_IGNORE  = 3'd5,
    FK_PENDING = 3'd6
  } frame_kind_t;

  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_HDR  = 2'd1,
    SEL_DAC  = 2'd2,
    SEL_EEP  = 2'd3
  } rd_sel_t;

  // Request in flight between the RAM read and the output queue
  typedef struct packed {
    logic       accepted;
    rd_sel_t    sel;
    logic       hi;
    logic [7:0] hdr;
    logic       vref;
    logic       dac_ok;
    logic       eep_ok;
  } s1_item_t;

  // One result
  typedef struct packed {
    logic [7:0] read_data;
    logic       accepted;
  } out_item_t;

endpackage

// ===== design/qdrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module qdrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/qdrs_outq.sv =====
// Small result queue between the datapath and the output channel.
module qdrs_outq
  import qdrs_pkg::*;
#(
  parameter int DEPTH = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  out_item_t                  push_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output out_item_t                  out_item,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  out_item_t         slot_r [DEPTH];
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [PW-1:0]     rp_r, rp_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_item  = slot_r[rp_r];
  assign count     = cnt_r;

  // Pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== design/quad_dac_i2c_register_slave_top.sv =====
// Top level of the quad 12-bit DAC register slave.
// Takes one request per clock when the result queue has room (write byte,
// stop, read byte, tick) and returns one result per request. A result passes
// through the channel-word RAM read register and then the result queue.
// Sustained rate is one request per cycle while out_ready stays high, set by the
// single RAM read port and the output queue depth (OUT_DEPTH, at least 3). DAC and
// EEPROM words live in two 4-entry RAMs with per-entry valid flops that reset
// clears, so no clearing pass is needed; the vref bit of each DAC word sits in flops.
// The user writes configuration (address pins, EEPROM busy ticks) only while idle; the block does not enforce it.
`include "quad_dac_i2c_register_slave_top_macros.svh"

module quad_dac_i2c_register_slave_top
  import qdrs_pkg::*;
#(
  parameter int OUT_DEPTH = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_accepted,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int OCW = $clog2(OUT_DEPTH+1);

  // Configuration registers
  logic [2:0]  addr_bits_r;
  logic [15:0] busy_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_bits_r <= 3'd0;
      busy_cfg_r  <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ADDRESS_BITS: addr_bits_r <= cfg_wdata[2:0];
        REG_BUSY_TICKS:   busy_cfg_r  <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // Control state
  frame_kind_t       fk_r, fk_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [CH_W-1:0]   cur_ch_r, cur_ch_nxt;
  logic [7:0]        held_r, held_nxt;
  logic [15:0]       busy_r, busy_nxt;
  logic [CH_W-1:0]   rp_ch_r, rp_ch_nxt;
  logic [2:0]        rp_off_r, rp_off_nxt;
  logic [CHANNELS-1:0] vref_r, vref_nxt;
  logic [CHANNELS-1:0] dac_vld_r, dac_vld_nxt;
  logic [CHANNELS-1:0] eep_vld_r, eep_vld_nxt;

  logic              acc;
  logic              word_we, eep_we;
  logic [CH_W-1:0]   word_ch;
  logic [WORD_W-1:0] word_data;
  logic              rd_en;
  logic              s1_v_r;
  s1_item_t          s1_r, s1_nxt;
  logic [CODE_W-1:0] dac_rdata;
  logic [WORD_W-1:0] eep_rdata;
  logic [OCW-1:0]    q_count;
  logic [OCW:0]      occ;
  logic              in_acc;
  out_item_t         push_item, q_item;

  // Room for the request in flight plus this one
  assign occ      = {1'b0, q_count} + (OCW+1)'(s1_v_r);
  assign in_ready = occ < (OCW+1)'(OUT_DEPTH);
  assign in_acc   = in_valid && in_ready;
  assign rd_en    = in_acc && (in_cmd == CMD_READ);

  // Frame decode, busy timer and read pointer
  always_comb begin
    fk_nxt      = fk_r;
    cnt_nxt     = cnt_r;
    cur_ch_nxt  = cur_ch_r;
    held_nxt    = held_r;
    busy_nxt    = busy_r;
    rp_ch_nxt   = rp_ch_r;
    rp_off_nxt  = rp_off_r;
    vref_nxt    = vref_r;
    dac_vld_nxt = dac_vld_r;
    eep_vld_nxt = eep_vld_r;
    acc         = 1'b1;
    word_we     = 1'b0;
    eep_we      = 1'b0;
    word_ch     = cur_ch_r;
    word_data   = {held_r, in_byte_in};
    s1_nxt      = '0;
    s1_nxt.sel  = SEL_NONE;

    if (in_acc) begin
      case (in_cmd)
        CMD_WRITE: begin
          if (busy_r != 16'd0) begin
            acc = 1'b0;
          end else begin
            unique case (fk_r)
              FK_IDLE: begin
                if (in_byte_in[7:5] == OP_VREF) begin
                  // bit 3 goes to channel 0, bit 0 to channel 3
                  for (int c = 0; c < CHANNELS; c++) begin
                    vref_nxt[c] = in_byte_in[CHANNELS-1-c];
                  end
                  fk_nxt = FK_DONE;
                end else begin
                  cur_ch_nxt = in_byte_in[2:1];
                  cnt_nxt    = 4'd1;
                  if (in_byte_in[7:3] == OP_MULTI) begin
                    fk_nxt = FK_MULTI;
                  end else if (in_byte_in[7:3] == OP_SEQ) begin
                    fk_nxt = FK_SEQ;
                  end else if (in_byte_in[7:3] == OP_SINGLE) begin
                    fk_nxt = FK_SINGLE;
                  end else begin
                    cnt_nxt = 4'd0;
                    fk_nxt  = FK_IGNORE;
                    acc     = 1'b0;
                  end
                end
              end
              FK_MULTI: begin
                if (cnt_r == 4'd0) begin
                  if (in_byte_in[7:3] != OP_MULTI) begin
                    fk_nxt = FK_IGNORE;
                    acc    = 1'b0;
                  end else begin
                    cur_ch_nxt = in_byte_in[2:1];
                    cnt_nxt    = 4'd1;
                  end
                end else if (cnt_r == 4'd1) begin
                  held_nxt = in_byte_in;
                  cnt_nxt  = 4'd2;
                end else begin
                  word_we = 1'b1;
                  cnt_nxt = 4'd0;
                end
              end
              FK_SINGLE, FK_SEQ: begin
                if (cnt_r[0]) begin
                  held_nxt = in_byte_in;
                end else begin
                  word_we = 1'b1;
                  eep_we  = 1'b1;
                  if (fk_r == FK_SINGLE || cur_ch_r == CH_W'(CHANNELS-1)) begin
                    fk_nxt = FK_PENDING;
                  end else begin
                    cur_ch_nxt = cur_ch_r + 1'b1;
                  end
                end
                if (cnt_r < CNT_MAX) begin
                  cnt_nxt = cnt_r + 1'b1;
                end
              end
              default: acc = 1'b0;
            endcase
          end
        end
        CMD_STOP: begin
          if ((fk_r == FK_PENDING || (fk_r == FK_SEQ && cnt_r >= CNT_DATA0))
              && busy_r == 16'd0) begin
            busy_nxt = busy_cfg_r;
          end
          fk_nxt     = FK_IDLE;
          cnt_nxt    = 4'd0;
          rp_ch_nxt  = '0;
          rp_off_nxt = OFF_DAC_HDR;
        end
        CMD_READ: begin
          // Header bytes are built now; word bytes come from the RAMs
          s1_nxt.hdr = {(busy_r == 16'd0), 1'b1, rp_ch_r, addr_bits_r,
                        (rp_off_r == OFF_EEP_HDR)};
          s1_nxt.hi  = (rp_off_r == OFF_DAC_HI) || (rp_off_r == OFF_EEP_HI);
          s1_nxt.vref   = vref_r[rp_ch_r];
          s1_nxt.dac_ok = dac_vld_r[rp_ch_r];
          s1_nxt.eep_ok = eep_vld_r[rp_ch_r];
          if (rp_off_r == OFF_DAC_HDR || rp_off_r == OFF_EEP_HDR) begin
            s1_nxt.sel = SEL_HDR;
          end else if (rp_off_r < OFF_EEP_HDR) begin
            s1_nxt.sel = SEL_DAC;
          end else begin
            s1_nxt.sel = SEL_EEP;
          end
          if (rp_off_r == OFF_LAST) begin
            rp_off_nxt = OFF_DAC_HDR;
            rp_ch_nxt  = rp_ch_r + 1'b1;
          end else begin
            rp_off_nxt = rp_off_r + 1'b1;
          end
        end
        default: begin
          if (busy_r != 16'd0) begin
            busy_nxt = busy_r - 1'b1;
          end
        end
      endcase
    end
    s1_nxt.accepted = acc;

    // Word writes also land the vref bit and mark the entries valid
    if (word_we) begin
      vref_nxt[word_ch]    = word_data[WORD_W-1];
      dac_vld_nxt[word_ch] = 1'b1;
    end
    if (eep_we) begin
      eep_vld_nxt[word_ch] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fk_r      <= FK_IDLE;
      cnt_r     <= 4'd0;
      cur_ch_r  <= '0;
      held_r    <= 8'd0;
      busy_r    <= 16'd0;
      rp_ch_r   <= '0;
      rp_off_r  <= OFF_DAC_HDR;
      vref_r    <= '0;
      dac_vld_r <= '0;
      eep_vld_r <= '0;
      s1_v_r    <= 1'b0;
    end else begin
      fk_r      <= fk_nxt;
      cnt_r     <= cnt_nxt;
      cur_ch_r  <= cur_ch_nxt;
      held_r    <= held_nxt;
      busy_r    <= busy_nxt;
      rp_ch_r   <= rp_ch_nxt;
      rp_off_r  <= rp_off_nxt;
      vref_r    <= vref_nxt;
      dac_vld_r <= dac_vld_nxt;
      eep_vld_r <= eep_vld_nxt;
      s1_v_r    <= in_acc;
    end
  end

  // Payload of the request in flight
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  // Channel word stores
  qdrs_ram #(
    .WIDTH(CODE_W),
    .DEPTH(CHANNELS)
  ) u_dac_ram (
    .clk  (clk),
    .we   (word_we),
    .waddr(word_ch),
    .wdata(word_data[CODE_W-1:0]),
    .re   (rd_en),
    .raddr(rp_ch_r),
    .rdata(dac_rdata)
  );

  qdrs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CHANNELS)
  ) u_eep_ram (
    .clk  (clk),
    .we   (eep_we),
    .waddr(word_ch),
    .wdata(word_data),
    .re   (rd_en),
    .raddr(rp_ch_r),
    .rdata(eep_rdata)
  );

  // Readback byte select
  logic [WORD_W-1:0] dac_word, eep_word, sel_word;

  always_comb begin
    dac_word = {s1_r.vref, s1_r.dac_ok ? dac_rdata : CODE_W'(0)};
    eep_word = s1_r.eep_ok ? eep_rdata : WORD_W'(0);
    sel_word = (s1_r.sel == SEL_EEP) ? eep_word : dac_word;
    push_item.accepted = s1_r.accepted;
    case (s1_r.sel)
      SEL_HDR:          push_item.read_data = s1_r.hdr;
      SEL_DAC, SEL_EEP: push_item.read_data = s1_r.hi ? sel_word[15:8] : sel_word[7:0];
      default:          push_item.read_data = 8'd0;
    endcase
  end

  qdrs_outq #(
    .DEPTH(OUT_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (s1_v_r),
    .push_item(push_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (q_item),
    .count    (q_count)
  );

  assign out_read_data = q_item.read_data;
  assign out_accepted  = q_item.accepted;

  // Checks
  `QDRS_ASSERT_IMP(a_no_overflow, 1'b1, occ <= (OCW+1)'(OUT_DEPTH), "result queue overrun")
  `QDRS_ASSERT_NXT(a_busy_refuse, in_acc && in_cmd == CMD_WRITE && busy_r != 16'd0, s1_v_r && !s1_r.accepted && $stable(fk_r), "write while busy was taken")
  `QDRS_ASSERT_NXT(a_stop_rewind, in_acc && in_cmd == CMD_STOP, rp_off_r == OFF_DAC_HDR && rp_ch_r == '0 && fk_r == FK_IDLE, "stop did not rewind")
  `QDRS_ASSERT_IMP(a_pend_idle, fk_r == FK_PENDING, cnt_r >= 4'd2, "pending frame without data")

endmodule
